>>> rtl/min_error_boundary_cut_macros.svh
// Assertion macros used by the boundary cut back end.
`ifndef MIN_ERROR_BOUNDARY_CUT_MACROS_SVH
`define MIN_ERROR_BOUNDARY_CUT_MACROS_SVH
`ifndef SYNTH
`define MEBC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define MEBC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define MEBC_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define MEBC_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

>>> rtl/mebc_pkg.sv
// Types and constants shared by the boundary cut modules.
package mebc_pkg;
  localparam int ErrW  = 13;
  localparam int CostW = 18;
  localparam int SumW  = 26;
  localparam logic [CostW-1:0] CostMax = 18'h3FFFF;

  localparam logic [1:0] CFG_DIR  = 2'd0;
  localparam logic [1:0] CFG_TILE = 2'd1;
  localparam logic [1:0] CFG_OVL  = 2'd2;

  localparam logic [1:0] PRED_UL = 2'd0;
  localparam logic [1:0] PRED_ST = 2'd1;
  localparam logic [1:0] PRED_DR = 2'd2;

  // One queue entry: squared error sum plus the last flag.
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            last;
  } mebc_item_t;

  function automatic logic [SumW-1:0] sq_diff(input logic signed [12:0] a,
                                              input logic signed [12:0] b);
    logic signed [13:0] d;
    logic [12:0] m;
    d = 14'(a) - 14'(b);
    m = d[13] ? 13'(-d) : 13'(d);
    return SumW'(m) * SumW'(m);
  endfunction
endpackage

>>> rtl/mebc_front.sv
// Front end: accepts pixel pairs, forms the squared Lab difference, feeds the queue.
module mebc_front import mebc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [10:0]          patch_lum,
  input  logic [11:0]          patch_gr,
  input  logic [11:0]          patch_by,
  input  logic [10:0]          quilt_lum,
  input  logic [11:0]          quilt_gr,
  input  logic [11:0]          quilt_by,
  input  logic                 in_last,
  output logic                 q_valid,
  input  logic                 q_ready,
  output mebc_item_t           q_item
);
  localparam int Depth = 2;
  mebc_item_t mem_r [Depth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  mebc_item_t it;
  logic push, pop;

  always_comb begin
    it.sum = sq_diff(13'({2'b0, patch_lum}), 13'({2'b0, quilt_lum}))
           + sq_diff(13'(signed'(patch_gr)), 13'(signed'(quilt_gr)))
           + sq_diff(13'(signed'(patch_by)), 13'(signed'(quilt_by)));
    it.last = in_last;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

>>> rtl/mebc_back.sv
// Back end: square root, error grid, dynamic program and backtrack.
`include "min_error_boundary_cut_macros.svh"
module mebc_back import mebc_pkg::*; #(
  parameter int MaxTile = 32,
  parameter int MaxOvl  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  mebc_item_t  q_item,
  input  logic        dir,
  input  logic [5:0]  tile_size,
  input  logic [4:0]  overlap_width,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [4:0]  step_index,
  output logic [3:0]  cut_position,
  output logic [CostW-1:0] path_cost,
  output logic        out_last
);
  localparam int SW = $clog2(MaxTile);
  localparam int PW = (MaxOvl > 1) ? $clog2(MaxOvl) : 1;
  localparam int AW = SW + PW;
  localparam int Depth = MaxTile * MaxOvl;
  localparam int DivN = SumW / 2;
  localparam int DW = ((SW > PW) ? SW : PW) + 2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_ROOT = 8'b00000010, S_WR   = 8'b00000100,
    S_DPRD = 8'b00001000, S_DPWR = 8'b00010000, S_BEST = 8'b00100000,
    S_BT   = 8'b01000000, S_EMIT = 8'b10000000
  } st_t;
  st_t st_r;

  logic [ErrW-1:0]  err_mem [Depth];
  logic [1:0]       pred_mem [Depth];
  logic [CostW-1:0] cost_r [MaxOvl];
  logic [CostW-1:0] next_r [MaxOvl];
  logic [3:0]       path_mem [MaxTile];
  logic [ErrW-1:0]  err_q;
  logic [1:0]       pred_q;

  // effective sizes
  logic [SW:0] steps;
  logic [PW:0] width;
  always_comb begin
    if (tile_size == 6'd0) steps = (SW+1)'(1);
    else if (7'(tile_size) > 7'(MaxTile)) steps = (SW+1)'(MaxTile);
    else steps = (SW+1)'(tile_size);
    if (overlap_width == 5'd0) width = (PW+1)'(1);
    else if (6'(overlap_width) > 6'(MaxOvl)) width = (PW+1)'(MaxOvl);
    else width = (PW+1)'(overlap_width);
  end

  logic [AW:0] cnt_r;
  logic        last_r, full_r;

  // The pixel count is divided by the band width (left cut) or the band length
  // (top cut) one quotient bit per cycle, alongside the square root.
  logic [DivN-1:0] dq_r;
  logic [DW-1:0]   drm_r;
  logic [DW-1:0]   dvs, dsh;
  logic [SW:0]     wr_s;
  logic [PW:0]     wr_p;
  always_comb begin
    dvs = dir ? DW'(steps) : DW'(width);
    dsh = {drm_r[DW-2:0], dq_r[DivN-1]};
    wr_s = dir ? (SW+1)'(drm_r) : (SW+1)'(dq_r);
    wr_p = dir ? (PW+1)'(dq_r) : (PW+1)'(drm_r);
  end

  // root unit
  logic [SumW-1:0] rv_r, rr_r;
  logic [SumW-1:0] rb_r;
  logic [SumW-1:0] rrb;
  assign rrb = rr_r + rb_r;

  // dp
  logic [SW:0] s_r;
  logic [PW:0] p_r;
  logic [CostW-1:0] best_c_r;
  logic [PW:0] best_p_r;
  logic [PW:0] cur_r;

  assign q_ready = (st_r == S_IDLE);

  function automatic logic [AW-1:0] adr(input logic [SW:0] s, input logic [PW:0] p);
    return AW'(s[SW-1:0]) * AW'(MaxOvl) + AW'(p[PW-1:0]);
  endfunction

  logic [CostW-1:0] cl, cm, cr, bc, nv;
  logic [1:0] bd;
  logic [CostW:0] sa;
  always_comb begin
    cm = cost_r[p_r[PW-1:0]];
    cl = (p_r != '0) ? cost_r[PW'(p_r - 1'b1)] : cm;
    cr = ((p_r + 1'b1) < width) ? cost_r[PW'(p_r + 1'b1)] : cm;
    if (p_r != '0) begin
      bc = cl; bd = PRED_UL;
      if (cm < bc) begin bc = cm; bd = PRED_ST; end
    end else begin
      bc = cm; bd = PRED_ST;
    end
    if (((p_r + 1'b1) < width) && cr < bc) begin bc = cr; bd = PRED_DR; end
    sa = {1'b0, bc} + (CostW+1)'(err_q);
    nv = (s_r == '0) ? CostW'(err_q) : (sa > {1'b0, CostMax} ? CostMax : CostW'(sa));
  end

  logic [PW+1:0] q;
  always_comb begin
    q = (PW+2)'(cur_r) + (PW+2)'(pred_q);
    q = (q >= 1) ? q - 1'b1 : '0;
    if (q >= (PW+2)'(width)) q = (PW+2)'(width) - 1'b1;
  end

  always_ff @(posedge clk) begin
    err_q  <= err_mem[adr(s_r, p_r)];
    pred_q <= pred_mem[adr(s_r, cur_r)];
    if (st_r == S_WR && !full_r) err_mem[adr(wr_s, wr_p)] <= (rv_r > rr_r) ?
        ErrW'(rr_r + 1'b1) : ErrW'(rr_r);
    if (st_r == S_DPWR && s_r != '0) pred_mem[adr(s_r, p_r)] <= bd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; out_tvalid <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          rv_r <= q_item.sum; rr_r <= '0; rb_r <= SumW'(1) << (SumW - 2);
          dq_r <= DivN'(cnt_r); drm_r <= '0;
          last_r <= q_item.last;
          full_r <= (cnt_r >= (AW+1)'(steps) * (AW+1)'(width));
          st_r <= S_ROOT;
        end
        S_ROOT: begin
          if (rb_r == '0) st_r <= S_WR;
          else begin
            if (rv_r >= rrb) begin rv_r <= rv_r - rrb; rr_r <= (rr_r >> 1) + rb_r; end
            else rr_r <= rr_r >> 1;
            rb_r <= rb_r >> 2;
            if (dsh >= dvs) begin drm_r <= dsh - dvs; dq_r <= {dq_r[DivN-2:0], 1'b1}; end
            else begin drm_r <= dsh; dq_r <= {dq_r[DivN-2:0], 1'b0}; end
          end
        end
        S_WR: begin
          if (!full_r) cnt_r <= cnt_r + 1'b1;
          if (last_r) begin s_r <= '0; p_r <= '0; st_r <= S_DPRD; end
          else st_r <= S_IDLE;
        end
        S_DPRD: st_r <= S_DPWR;
        S_DPWR: begin
          next_r[p_r[PW-1:0]] <= nv;
          if (p_r + 1'b1 >= width) begin
            for (int i = 0; i < MaxOvl; i++)
              cost_r[i] <= (i == int'(p_r)) ? nv : next_r[i];
            p_r <= '0;
            if (s_r + 1'b1 >= steps) st_r <= S_BEST;
            else begin
              s_r <= s_r + 1'b1; st_r <= S_DPRD;
            end
          end else begin
            p_r <= p_r + 1'b1; st_r <= S_DPRD;
          end
        end
        S_BEST: begin
          if (p_r < width) begin
            if (p_r == '0 || cost_r[p_r[PW-1:0]] < best_c_r) begin
              best_c_r <= cost_r[p_r[PW-1:0]]; best_p_r <= p_r;
            end
            p_r <= p_r + 1'b1;
          end else begin
            cur_r <= best_p_r;
            path_mem[s_r[SW-1:0]] <= 4'(best_p_r);
            st_r <= (s_r == '0) ? S_EMIT : S_BT;
            p_r <= '0;
          end
        end
        S_BT: begin
          // pred_q for (s_r, cur_r) is registered; p_r marks the wait for it.
          if (p_r == '0) p_r <= (PW+1)'(1);
          else begin
            p_r <= '0;
            path_mem[SW'(s_r - 1'b1)] <= 4'(q);
            cur_r <= (PW+1)'(q);
            s_r <= s_r - 1'b1;
            if (s_r == (SW+1)'(1)) st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_tvalid || out_tready) begin
            if (out_tvalid && out_last) begin
              out_tvalid <= 1'b0; cnt_r <= '0;
              st_r <= S_IDLE;
            end else begin
              out_tvalid <= 1'b1;
              step_index <= 5'(s_r);
              cut_position <= path_mem[s_r[SW-1:0]];
              path_cost <= best_c_r;
              out_last <= (s_r + 1'b1 >= steps);
              s_r <= s_r + 1'b1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MEBC_ASSERT_IMP(a_ready_idle, clk, rst_n, q_ready, st_r == S_IDLE)
  `MEBC_ASSERT_IMP(a_out_emit, clk, rst_n, out_tvalid, st_r == S_EMIT)
  `MEBC_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(st_r))
  `MEBC_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(cut_position))
endmodule

>>> rtl/min_error_boundary_cut.sv
// Top level of the minimum error boundary cut block.
// Each pixel pair in the back end is paced by the iterative square root
// (one root bit a cycle); the front queue holds two beats. After the last pixel the DP
// fills the cost rows, the end search picks the cheapest position, the backtrack
// walks the predecessors, and then one result beat per step is sent.
module min_error_boundary_cut import mebc_pkg::*; #(
  parameter int MaxTile = 32,
  parameter int MaxOvl  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // patch_lum[10:0], patch_green_red[22:11], patch_blue_yellow[34:23],
  // quilt_lum[45:35], quilt_green_red[57:46], quilt_blue_yellow[69:58], zero fill
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // step_index[4:0], cut_position[8:5], path_cost[26:9], zero fill
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  logic       dir_r;
  logic [5:0] tile_r;
  logic [4:0] ovl_r;
  logic       q_valid, q_ready;
  mebc_item_t q_item;
  logic [4:0] step_index;
  logic [3:0] cut_position;
  logic [CostW-1:0] path_cost;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0; tile_r <= 6'd32; ovl_r <= 5'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIR:  dir_r <= cfg_data[0];
        CFG_TILE: tile_r <= cfg_data;
        CFG_OVL:  ovl_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  mebc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .patch_lum(in_tdata[10:0]), .patch_gr(in_tdata[22:11]), .patch_by(in_tdata[34:23]),
    .quilt_lum(in_tdata[45:35]), .quilt_gr(in_tdata[57:46]), .quilt_by(in_tdata[69:58]),
    .in_last(in_tlast), .q_valid, .q_ready, .q_item
  );

  mebc_back #(.MaxTile(MaxTile), .MaxOvl(MaxOvl)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .dir(dir_r), .tile_size(tile_r), .overlap_width(ovl_r),
    .out_tvalid, .out_tready, .step_index, .cut_position, .path_cost,
    .out_last(out_tlast)
  );

  assign out_tdata = {5'd0, path_cost, cut_position, step_index};
endmodule

>>> dv/tb_min_error_boundary_cut.sv
// Self-checking testbench for the minimum error boundary cut block.
`timescale 1ns / 100ps

module tb_min_error_boundary_cut;
  import mebc_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int GridSlots = 32 * 16;
  localparam int WatchLimit = 5000;
  localparam int LongHold = 300;

  typedef struct {
    logic [10:0]        p_lum;
    logic signed [11:0] p_gr;
    logic signed [11:0] p_by;
    logic [10:0]        q_lum;
    logic signed [11:0] q_gr;
    logic signed [11:0] q_by;
    logic               last;
  } pixel_t;

  typedef struct {
    logic [4:0]  step;
    logic [3:0]  cut;
    logic [17:0] cost;
    logic        last;
  } cut_step_t;

  class cut_scoreboard;
    logic        dir;
    logic [5:0]  tile;
    logic [4:0]  ovl;
    logic [12:0] err_grid[GridSlots];
    logic [1:0]  pred_grid[GridSlots];
    bit          written[GridSlots];
    int          pix_count;
    cut_step_t   expected_steps[$];
    int          errors;

    function void reset_state();
      dir = 1'b0;
      tile = 6'd32;
      ovl = 5'd8;
      pix_count = 0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int steps();
      return (tile == 0) ? 1 : (tile > 32) ? 32 : int'(tile);
    endfunction

    function int width();
      return (ovl == 0) ? 1 : (ovl > 16) ? 16 : int'(ovl);
    endfunction

    function int capacity();
      return steps() * width();
    endfunction

    // True when every grid entry the cut will read has been filled at some point.
    function bit grid_ready();
      for (int s = 0; s < steps(); s++)
        for (int p = 0; p < width(); p++)
          if (!written[s * 16 + p]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] data);
      case (idx)
        CFG_DIR:  dir = data[0];
        CFG_TILE: tile = data;
        CFG_OVL:  ovl = data[4:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction

    function void note_pixel(pixel_t px);
      int unsigned dl, dgr, dby, sum, root, t;
      int ns, nw, slot, best;
      int unsigned cost[16], nxt[16], bc;
      logic [1:0] bd;
      int route[32];
      cut_step_t st;
      ns = steps();
      nw = width();
      if (pix_count < ns * nw) begin
        if (!dir) slot = (pix_count / nw) * 16 + pix_count % nw;
        else slot = (pix_count % ns) * 16 + pix_count / ns;
        dl = (px.p_lum > px.q_lum) ? px.p_lum - px.q_lum : px.q_lum - px.p_lum;
        dgr = (px.p_gr > px.q_gr) ? px.p_gr - px.q_gr : px.q_gr - px.p_gr;
        dby = (px.p_by > px.q_by) ? px.p_by - px.q_by : px.q_by - px.p_by;
        sum = dl * dl + dgr * dgr + dby * dby;
        root = 0;
        for (int b = 13; b >= 0; b--) begin
          t = root | (1 << b);
          if (t * t <= sum) root = t;
        end
        if (sum - root * root > root) root++;
        err_grid[slot] = root[12:0];
        written[slot] = 1'b1;
        pix_count++;
      end
      if (!px.last) return;
      for (int p = 0; p < nw; p++) cost[p] = err_grid[p];
      for (int s = 1; s < ns; s++) begin
        for (int p = 0; p < nw; p++) begin
          // Ties favor the lower position: up-left, then straight, then down-right.
          if (p > 0) begin
            bc = cost[p - 1];
            bd = PRED_UL;
            if (cost[p] < bc) begin
              bc = cost[p];
              bd = PRED_ST;
            end
          end else begin
            bc = cost[p];
            bd = PRED_ST;
          end
          if (p + 1 < nw && cost[p + 1] < bc) begin
            bc = cost[p + 1];
            bd = PRED_DR;
          end
          pred_grid[s * 16 + p] = bd;
          nxt[p] = bc + err_grid[s * 16 + p];
          if (nxt[p] > CostMax) nxt[p] = CostMax;
        end
        for (int p = 0; p < nw; p++) cost[p] = nxt[p];
      end
      best = 0;
      for (int p = 1; p < nw; p++) if (cost[p] < cost[best]) best = p;
      route[ns - 1] = best;
      for (int s = ns - 1; s > 0; s--) begin
        t = route[s] + pred_grid[s * 16 + route[s]];
        t = (t >= 1) ? t - 1 : 0;
        route[s - 1] = (t >= nw) ? nw - 1 : t;
      end
      for (int s = 0; s < ns; s++) begin
        st.step = s[4:0];
        st.cut = route[s][3:0];
        st.cost = cost[best][17:0];
        st.last = (s == ns - 1);
        expected_steps = {expected_steps, st};
      end
      pix_count = 0;
    endfunction

    function void check_step(logic [31:0] data, logic last);
      cut_step_t e;
      if (expected_steps.size() == 0) begin
        $error("unexpected result beat: data %h last %b", data, last);
        errors++;
        return;
      end
      e = expected_steps.pop_front();
      if (data[4:0] !== e.step) begin
        $error("step_index: expected %0d, actual %0d", e.step, data[4:0]);
        errors++;
      end
      if (data[8:5] !== e.cut) begin
        $error("cut_position: expected %0d, actual %0d", e.cut, data[8:5]);
        errors++;
      end
      if (data[26:9] !== e.cost) begin
        $error("path_cost: expected %0d, actual %0d", e.cost, data[26:9]);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_step: expected %b, actual %b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  cut_scoreboard sb;
  bit calm;
  bit hold_req;
  int pixels_sent;
  int quiet_cycles;

  min_error_boundary_cut uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic pixel_t make_pixel(int pl, int pgr, int pby, int ql, int qgr, int qby,
                                        bit last);
    pixel_t px;
    px.p_lum = pl[10:0];
    px.p_gr = pgr[11:0];
    px.p_by = pby[11:0];
    px.q_lum = ql[10:0];
    px.q_gr = qgr[11:0];
    px.q_by = qby[11:0];
    px.last = last;
    return px;
  endfunction

  function automatic pixel_t rand_pixel(bit last);
    pixel_t px;
    px = make_pixel($urandom_range(0, 1600), $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 1600), $urandom_range(0, 4095), $urandom_range(0, 4095),
                    last);
    // Matching pixels give zero error and so plenty of tied paths.
    if ($urandom_range(0, 3) == 0) begin
      px.q_lum = px.p_lum;
      px.q_gr = px.p_gr;
      px.q_by = px.p_by;
    end
    return px;
  endfunction

  task automatic send_pixel(pixel_t px);
    repeat (draw_gap()) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, px.q_by, px.q_gr, px.q_lum, px.p_by, px.p_gr, px.p_lum};
    in_tlast <= px.last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] data);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(logic dir, logic [5:0] tile, logic [4:0] ovl);
    wait_idle();
    write_reg(CFG_DIR, {5'b0, dir});
    write_reg(CFG_TILE, tile);
    write_reg(CFG_OVL, {1'b0, ovl});
  endtask

  // Sends one band: complete, cut short by an early last pixel, or padded with surplus.
  task automatic send_band(bit early, bit surplus);
    int n;
    n = sb.capacity();
    if (early) n = $urandom_range(1, n - 1);
    else if (surplus) n = n + $urandom_range(1, 4);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel(i == n - 1));
  endtask

  // Result side: random stalls, and one long hold when asked for.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_tready <= 1'b0;
        for (int i = 0; i < LongHold; i++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        repeat (draw_gap()) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_step(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("tb_min_error_boundary_cut: done, errors");
      $finish;
    end
  end

  initial begin
    int runs;
    int pick;
    int phase_no;
    logic [5:0] tile;
    logic [4:0] ovl;
    sb = new();
    sb.reset_state();
    calm = 1'b0;
    hold_req = 1'b0;
    pixels_sent = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DIR;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A two by one band; extreme errors, then a zero error pixel.
    configure(1'b0, 6'd2, 5'd1);
    send_pixel(make_pixel(1600, 2047, -2048, 0, -2048, 2047, 1'b0));
    send_pixel(make_pixel(700, 5, 5, 700, 5, 5, 1'b1));
    send_pixel(make_pixel(0, -2048, 2047, 1600, 2047, -2048, 1'b0));
    send_pixel(make_pixel(2047, -1, -1, 2047, -1, -1, 1'b0));
    // Surplus pixels beyond the band are ignored; last still triggers the cut.
    send_pixel(make_pixel(1600, 0, 0, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(100, 9, 9, 0, 0, 0, 1'b1));
    // Zero registers saturate to a one by one band; spare index is ignored.
    configure(1'b0, 6'd0, 5'd0);
    write_reg(CFG_SPARE, 6'h3F);
    send_pixel(make_pixel(1023, 1365, -1366, 512, -1, 0, 1'b1));
    // Top cut, then an early last pixel that reuses the earlier entries.
    configure(1'b1, 6'd3, 5'd2);
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel(i == 5));
    send_pixel(rand_pixel(1'b0));
    send_pixel(rand_pixel(1'b1));
    // Longest and widest bands, both saturated from above.
    configure(1'b1, 6'd63, 5'd1);
    send_band(1'b0, 1'b0);
    configure(1'b0, 6'd2, 5'd31);
    send_band(1'b0, 1'b0);

    phase_no = 0;
    while (pixels_sent < 180) begin
      pick = $urandom_range(0, 11);
      tile = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd1 :
             (pick == 2) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(2, 6));
      pick = $urandom_range(0, 11);
      ovl = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(17, 31)) :
            5'($urandom_range(1, 4));
      // Keep the bands short so the run stays near its item budget.
      if (ovl > 5'd4) tile = 6'd2;
      else if (tile > 6'd6) ovl = 5'd1;
      if (phase_no == 0) begin
        tile = 6'd4;
        ovl = 5'd2;
      end
      configure(1'($urandom_range(0, 1)), tile, ovl);
      calm = ($urandom_range(0, 3) == 0);
      runs = $urandom_range(1, 3);
      if (phase_no == 0) begin
        // Hold results back while more bands pile up behind them.
        runs = 3;
        calm = 1'b1;
        hold_req = 1'b1;
      end
      for (int r = 0; r < runs; r++) begin
        pick = $urandom_range(0, 9);
        if (phase_no != 0 && pick >= 7 && pick <= 8 && sb.capacity() >= 2 &&
            sb.grid_ready())
          send_band(1'b1, 1'b0);
        else
          send_band(1'b0, pick == 9);
      end
      phase_no++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_min_error_boundary_cut: done, clean");
    end else begin
      if (sb.pending() != 0) $error("%0d expected cut steps never arrived", sb.pending());
      $display("tb_min_error_boundary_cut: done, errors");
    end
    $finish;
  end
endmodule

>>> min_error_boundary_cut.f
+incdir+rtl
rtl/mebc_pkg.sv
rtl/mebc_front.sv
rtl/mebc_back.sv
rtl/min_error_boundary_cut.sv
dv/tb_min_error_boundary_cut.sv
